FILE: rtl/pcu_pkg.sv
// Shared types, constants and the per-index write mask for the configuration
// unlock register file. No dependencies.
`default_nettype none

package pcu_pkg;

  localparam int NumSettings = 15;

  // Access kinds.
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncRead  = 1'b1;

  // Configuration register indexes.
  localparam logic CfgXtAttach    = 1'b0;
  localparam logic CfgDiskPresent = 1'b1;

  // Fixed unlock ports and the magic byte of the sequence.
  localparam logic [15:0] UnlockPortA = 16'h02fa;
  localparam logic [15:0] UnlockPortB = 16'h03fa;
  localparam logic [7:0]  UnlockMagic = 8'h36;

  // Index that reads back the port base and closes the mode when written.
  localparam logic [3:0] IndexBaseReadback = 4'd15;

  typedef logic [NumSettings-1:0][7:0] settings_t;

  // Power-on values, index 14 on the left down to index 0 on the right.
  localparam settings_t SettingDefaults = {
    8'h00, 8'h00, 8'ha0, 8'h00, 8'h00, 8'hb0, 8'h00, 8'h00,
    8'h9e, 8'h00, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h0c
  };

  typedef struct packed {
    logic        func;
    logic [15:0] port;
    logic [7:0]  wdata;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       config_active;
    logic       serial_enabled;
    logic [9:0] serial_base;
    logic       parallel_enabled;
    logic [9:0] parallel_base;
    logic       parallel_extended;
    logic       ide_enabled;
    logic       xt_disk_enabled;
    logic       floppy_enabled;
    logic       floppy_power_down;
    logic [9:0] pointer_base;
  } out_beat_t;

  // Write request into the settings bytes.
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } set_wr_t;

  // New value of a settings byte after a write, with the bits each index protects.
  function automatic logic [7:0] store_mask(input logic [3:0] idx, input logic [7:0] old,
                                            input logic [7:0] v);
    logic [7:0] res;
    case (idx)
      4'd0:    res = (old & 8'h10) | (v & 8'hef);
      4'd1:    res = (old & 8'h07) | (v & 8'hf8);
      4'd2:    res = (old & 8'h08) | (v & 8'hf0);
      4'd4:    res = (old & 8'h01) | (v & 8'hfe);
      4'd5:    res = old;
      4'd14:   res = (old & 8'h20) | (v & 8'hdf);
      default: res = v;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pcu_settings.sv
// The fifteen settings bytes with their write masks and power-on values.
// Depends on pcu_pkg.
`default_nettype none

module pcu_settings (
  input  wire                   clk,
  input  wire                   rst,
  input  wire pcu_pkg::set_wr_t wr,
  output pcu_pkg::settings_t    settings_next
);
  import pcu_pkg::*;

  settings_t settings;

  // The next view is exported so that a result reflects its own write.
  always_comb begin
    for (int i = 0; i < NumSettings; i++) begin
      if (wr.en && wr.idx == 4'(i)) begin
        settings_next[i] = store_mask(4'(i), settings[i], wr.data);
      end else begin
        settings_next[i] = settings[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settings <= SettingDefaults;
    end else begin
      settings <= settings_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/peripheral_config_unlock_regfile_top.sv
// Top level of the configuration unlock register file.
// Depends on pcu_pkg and pcu_settings.
`default_nettype none

// Each input beat is one I/O bus access. Five writes to the two fixed ports
// (a byte V to 0x2fa, 255-V to 0x3fa, 0x36 to 0x3fa, a base byte B to 0x3fa,
// then a checksum C to 0x2fa with B+C = 255 modulo 256) open configuration
// mode with the index port at 4*B and the data port at 4*B+1. In that mode
// index 0 to 14 address the settings bytes, index 15 reads B back and a write
// to it closes the mode. Every access yields exactly one result beat with the
// read data and the decoded enables and bases of the peripheral functions.
// The block takes one beat per cycle while its result beats are taken: an
// accepted beat is held in an input register and resolved by a single pass
// of compares and masks into the result register, where the result beat is
// offered. The input register holds its beat while the result register is
// full and not taken. The two configuration registers are written through
// the plain write port; the user must do so only while no access is in
// flight, which the block itself does not enforce.

module peripheral_config_unlock_regfile_top (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire pcu_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output pcu_pkg::out_beat_t     out_data,
  input  wire                    cfg_we,
  input  wire                    cfg_index,
  input  wire                    cfg_wdata
);
  import pcu_pkg::*;

  // Unlock sequence positions.
  localparam logic [2:0] StepIdle       = 3'd0;
  localparam logic [2:0] StepComplement = 3'd1;
  localparam logic [2:0] StepMagic      = 3'd2;
  localparam logic [2:0] StepBase       = 3'd3;
  localparam logic [2:0] StepChecksum   = 3'd4;

  // Configuration registers.
  logic xt_attach_mode;
  logic hard_disk_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      xt_attach_mode    <= 1'b0;
      hard_disk_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgXtAttach:    xt_attach_mode    <= cfg_wdata;
        CfgDiskPresent: hard_disk_present <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Pipeline handshake: the result register frees up when empty or taken,
  // and the input register moves forward whenever the result register frees.
  logic     s1_valid;
  in_beat_t s1_beat;
  logic     out_open;
  logic     s1_go;

  assign out_open = !out_valid || out_ready;
  assign s1_go    = s1_valid && out_open;
  assign in_ready = !s1_valid || out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat <= in_data;
    end
  end

  // Unlock and mode state. The index port base is kept as the byte B.
  logic [2:0] unlock_step, unlock_step_next;
  logic       mode_open, mode_open_next;
  logic [7:0] expected_complement, expected_complement_next;
  logic [7:0] base_byte, base_byte_next;
  logic [3:0] current_index, current_index_next;

  set_wr_t    set_wr;
  settings_t  settings_next;
  logic [7:0] rdata;

  pcu_settings u_settings (
    .clk           (clk),
    .rst           (rst),
    .wr            (set_wr),
    .settings_next (settings_next)
  );

  // Decode of one write access. The index and data ports are the ones in
  // force before this access; a base write takes effect from the next access.
  always_comb begin
    logic [15:0] idx_port;
    logic [15:0] dat_port;
    logic        decoded;
    logic        advance;
    logic [7:0]  v;

    idx_port = {6'd0, base_byte, 2'b00};
    dat_port = {6'd0, base_byte, 2'b01};
    v        = s1_beat.wdata;
    decoded  = 1'b0;
    advance  = 1'b0;

    unlock_step_next         = unlock_step;
    mode_open_next           = mode_open;
    expected_complement_next = expected_complement;
    base_byte_next           = base_byte;
    current_index_next       = current_index;
    set_wr                   = '0;

    if (s1_beat.func == FuncWrite) begin
      if (s1_beat.port == UnlockPortA) begin
        decoded = 1'b1;
        if (unlock_step == StepIdle) begin
          advance                  = 1'b1;
          expected_complement_next = 8'hff - v;
        end else if (unlock_step == StepChecksum) begin
          mode_open_next = ((base_byte + v) == 8'hff);
        end
      end else if (s1_beat.port == UnlockPortB) begin
        decoded = 1'b1;
        if (unlock_step == StepComplement && v == expected_complement) begin
          advance = 1'b1;
        end else if (unlock_step == StepMagic && v == UnlockMagic) begin
          advance = 1'b1;
        end else if (unlock_step == StepBase) begin
          base_byte_next = v;
          advance        = 1'b1;
        end
      end

      // The checksum write above may have just opened or closed the mode.
      if (mode_open_next) begin
        if (s1_beat.port == idx_port) begin
          decoded            = 1'b1;
          current_index_next = v[3:0];
        end else if (s1_beat.port == dat_port) begin
          decoded = 1'b1;
          if (current_index == IndexBaseReadback) begin
            mode_open_next = 1'b0;
          end else begin
            set_wr.en   = s1_go;
            set_wr.idx  = current_index;
            set_wr.data = v;
          end
        end
      end

      if (decoded) begin
        unlock_step_next = advance ? unlock_step + 3'd1 : StepIdle;
      end
    end
  end

  // Read data. Only the index and data ports answer, and only while the mode
  // is open; a read never writes, so the settings view is the stored one.
  always_comb begin
    rdata = 8'hff;
    if (s1_beat.func == FuncRead && mode_open) begin
      if (s1_beat.port == {6'd0, base_byte, 2'b00}) begin
        rdata = {4'd0, current_index};
      end else if (s1_beat.port == {6'd0, base_byte, 2'b01}) begin
        if (current_index == IndexBaseReadback) begin
          rdata = base_byte;
        end else begin
          rdata = settings_next[current_index];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_step         <= StepIdle;
      mode_open           <= 1'b0;
      expected_complement <= 8'd0;
      base_byte           <= 8'd0;
      current_index       <= 4'd0;
    end else if (s1_go) begin
      unlock_step         <= unlock_step_next;
      mode_open           <= mode_open_next;
      expected_complement <= expected_complement_next;
      base_byte           <= base_byte_next;
      current_index       <= current_index_next;
    end
  end

  // Result beat, decoded from the settings as they stand after this access.
  out_beat_t  result;
  logic [7:0] r12;

  assign r12 = settings_next[12];

  always_comb begin
    result.rdata             = rdata;
    result.config_active     = mode_open_next;
    result.serial_enabled    = settings_next[0][2];
    result.serial_base       = {settings_next[4], 2'b00};
    result.parallel_enabled  = settings_next[0][3];
    result.parallel_base     = {settings_next[6], 2'b00};
    result.parallel_extended = settings_next[1][6];
    result.ide_enabled       = r12[7] && !r12[6] && !xt_attach_mode;
    result.xt_disk_enabled   = r12[7] && r12[6] && xt_attach_mode && hard_disk_present;
    result.floppy_enabled    = r12[5];
    result.floppy_power_down = r12[4];
    result.pointer_base      = {settings_next[13], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for peripheral_config_unlock_regfile_top: bus accesses in,
// one predicted result beat per access compared field by field. Uses pcu_pkg.

module testbench;
  import pcu_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int DrainCycles = 8;   // the block answers through its input and result registers
  localparam int HoldCycles  = 64;  // long receiver hold-off that fills the block

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic      cfg_wdata;

  peripheral_config_unlock_regfile_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block's straps and internal state. It advances once per
  // accepted input beat, in the same order the block sees the accesses.
  logic       strap_xt;
  logic       strap_disk;
  logic [2:0] seq_step;
  logic       mode_on;
  logic [7:0] want_compl;
  logic [9:0] port_base;
  logic [3:0] sel_index;
  logic [7:0] settings [NumSettings];

  // Result beats predicted for accepted accesses and not yet seen at the output.
  out_beat_t  pending_results [$];
  out_beat_t  head_beat;

  int         errors;
  int         accesses_sent;
  int         burst_left;
  bit         tx_steady;
  bit         hold_pending;
  bit         hold_active;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Works out the result of one bus access and moves the shadow state on.
  // Port compares use the index and data ports as they were before the access,
  // so a base rewrite at step three only takes effect from the next beat.
  function automatic out_beat_t predict_access(input in_beat_t acc);
    out_beat_t   res;
    logic [15:0] idx_port;
    logic [15:0] dat_port;
    logic [7:0]  v;
    logic [7:0]  old;
    logic [7:0]  sum;
    logic        hit;
    logic        step_on;
    idx_port = {6'd0, port_base};
    dat_port = idx_port + 16'd1;
    v        = acc.wdata;
    hit      = 1'b0;
    step_on  = 1'b0;
    res       = '0;
    res.rdata = 8'hff;
    if (acc.func == FuncRead) begin
      // Only the index and data ports answer, and only while the mode is open.
      if (mode_on) begin
        if (acc.port == idx_port) begin
          res.rdata = {4'd0, sel_index};
        end else if (acc.port == dat_port) begin
          res.rdata = (sel_index == IndexBaseReadback) ? port_base[9:2] : settings[sel_index];
        end
      end
    end else begin
      if (acc.port == UnlockPortA) begin
        hit = 1'b1;
        if (seq_step == 3'd0) begin
          step_on    = 1'b1;
          want_compl = 8'hff - v;
        end else if (seq_step == 3'd4) begin
          // The checksum decides both ways: a bad one closes an open mode.
          sum     = port_base[9:2] + v;
          mode_on = (sum == 8'hff);
        end
      end else if (acc.port == UnlockPortB) begin
        hit = 1'b1;
        if (seq_step == 3'd1 && v == want_compl) begin
          step_on = 1'b1;
        end else if (seq_step == 3'd2 && v == UnlockMagic) begin
          step_on = 1'b1;
        end else if (seq_step == 3'd3) begin
          port_base = {v, 2'b00};
          step_on   = 1'b1;
        end
      end
      if (mode_on) begin
        if (acc.port == idx_port) begin
          hit       = 1'b1;
          sel_index = v[3:0];
        end else if (acc.port == dat_port) begin
          hit = 1'b1;
          if (sel_index == IndexBaseReadback) begin
            mode_on = 1'b0;
          end else begin
            old = settings[sel_index];
            case (sel_index)
              4'd0:    settings[sel_index] = (old & 8'h10) | (v & 8'hef);
              4'd1:    settings[sel_index] = (old & 8'h07) | (v & 8'hf8);
              4'd2:    settings[sel_index] = (old & 8'h08) | (v & 8'hf0);
              4'd4:    settings[sel_index] = (old & 8'h01) | (v & 8'hfe);
              4'd5:    settings[sel_index] = old;
              4'd14:   settings[sel_index] = (old & 8'h20) | (v & 8'hdf);
              default: settings[sel_index] = v;
            endcase
          end
        end
      end
      // Any decoded write that does not advance the sequence starts it over.
      if (hit) seq_step = step_on ? seq_step + 3'd1 : 3'd0;
    end
    res.config_active     = mode_on;
    res.serial_enabled    = settings[0][2];
    res.serial_base       = {settings[4], 2'b00};
    res.parallel_enabled  = settings[0][3];
    res.parallel_base     = {settings[6], 2'b00};
    res.parallel_extended = settings[1][6];
    res.ide_enabled       = settings[12][7] & ~settings[12][6] & ~strap_xt;
    res.xt_disk_enabled   = settings[12][7] & settings[12][6] & strap_xt & strap_disk;
    res.floppy_enabled    = settings[12][5];
    res.floppy_power_down = settings[12][4];
    res.pointer_base      = {settings[13], 2'b00};
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Output side is checked before the input side is predicted, so a beat that
  // comes out with nothing outstanding can never pair with a newer access.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no access outstanding");
          errors++;
        end else begin
          head_beat = pending_results.pop_front();
          check_field("rdata", 16'(head_beat.rdata), 16'(out_data.rdata));
          check_field("config_active", 16'(head_beat.config_active),
                      16'(out_data.config_active));
          check_field("serial_enabled", 16'(head_beat.serial_enabled),
                      16'(out_data.serial_enabled));
          check_field("serial_base", 16'(head_beat.serial_base), 16'(out_data.serial_base));
          check_field("parallel_enabled", 16'(head_beat.parallel_enabled),
                      16'(out_data.parallel_enabled));
          check_field("parallel_base", 16'(head_beat.parallel_base),
                      16'(out_data.parallel_base));
          check_field("parallel_extended", 16'(head_beat.parallel_extended),
                      16'(out_data.parallel_extended));
          check_field("ide_enabled", 16'(head_beat.ide_enabled), 16'(out_data.ide_enabled));
          check_field("xt_disk_enabled", 16'(head_beat.xt_disk_enabled),
                      16'(out_data.xt_disk_enabled));
          check_field("floppy_enabled", 16'(head_beat.floppy_enabled),
                      16'(out_data.floppy_enabled));
          check_field("floppy_power_down", 16'(head_beat.floppy_power_down),
                      16'(out_data.floppy_power_down));
          check_field("pointer_base", 16'(head_beat.pointer_base),
                      16'(out_data.pointer_base));
        end
      end
      if (in_valid && in_ready) pending_results.push_back(predict_access(in_data));
    end
  end

  // Receiver: short ready runs, short stalls and now and then a long ready run.
  // A test can ask for one long hold-off; it is counted here, in cycles.
  initial begin : rx_pattern
    out_ready   = 1'b0;
    hold_active = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_active  = 1'b1;
        out_ready   <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_active  = 1'b0;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            out_ready <= 1'b1;
            repeat (63) @(negedge clk);
          end
          1, 2: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
          end
          default: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 9)) @(negedge clk);
          end
        endcase
      end
    end
  end

  // Offers one access and holds it until the beat is taken. Outside steady
  // stretches the sender drops valid for a random pause after each burst.
  task automatic send_access(input logic kind, input logic [15:0] addr,
                             input logic [7:0] data);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= {kind, addr, data};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accesses_sent++;
    if (!tx_steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
    send_access(FuncWrite, addr, data);
  endtask

  // Reads carry a random byte, which the block must ignore.
  task automatic bus_read(input logic [15:0] addr);
    send_access(FuncRead, addr, 8'($urandom));
  endtask

  // Full five-write unlock with ports at 4*base. A bad checksum still runs
  // the whole sequence, and closes the mode if it was open.
  task automatic open_mode(input logic [7:0] base, input bit good);
    logic [7:0] key;
    logic [7:0] check;
    key   = 8'($urandom);
    check = 8'hff - base;
    if (!good) check = check ^ 8'($urandom_range(1, 255));
    bus_write(UnlockPortA, key);
    bus_write(UnlockPortB, 8'hff - key);
    bus_write(UnlockPortB, UnlockMagic);
    bus_write(UnlockPortB, base);
    bus_write(UnlockPortA, check);
  endtask

  // Drops valid and waits until every predicted beat has come out.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CfgXtAttach) strap_xt = val;
    else strap_disk = val;
  endtask

  // One configuration session: unlock, then a mix of index and data port
  // traffic with some stray accesses, base moves and failed re-unlocks.
  task automatic run_session(input logic [7:0] base, input int ops);
    logic [15:0] ip;
    logic [15:0] dp;
    logic [7:0]  nb;
    logic [3:0]  pick_idx;
    int          pick;
    ip = {6'd0, base, 2'b00};
    dp = ip + 16'd1;
    open_mode(base, 1'b1);
    repeat (ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // Index 12 is favored so the disk and floppy decodes see many values.
        case ($urandom_range(0, 9))
          0:       pick_idx = IndexBaseReadback;
          1, 2:    pick_idx = 4'd12;
          default: pick_idx = 4'($urandom_range(0, 14));
        endcase
        bus_write(ip, {4'($urandom), pick_idx});
      end else if (pick < 60) begin
        bus_write(dp, 8'($urandom));
      end else if (pick < 75) begin
        bus_read(dp);
      end else if (pick < 82) begin
        bus_read(ip);
      end else if (pick < 90) begin
        send_access(1'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        // Broken start: a wrong complement after the first byte.
        nb = 8'($urandom);
        bus_write(UnlockPortA, nb);
        bus_write(UnlockPortB, nb);
      end else begin
        // Re-unlock while open: the ports move at step three; a bad
        // checksum then closes the mode.
        nb = 8'($urandom);
        open_mode(nb, $urandom_range(0, 2) != 0);
        ip = {6'd0, nb, 2'b00};
        dp = ip + 16'd1;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      bus_write(ip, {4'($urandom), IndexBaseReadback});
      bus_write(dp, 8'($urandom));
    end
  endtask

  // Stray traffic and unlock sequences cut short at a random step.
  task automatic run_noise();
    logic [7:0]  key;
    logic [15:0] addr;
    int          depth;
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       addr = UnlockPortA;
          1:       addr = UnlockPortB;
          2:       addr = 16'($urandom_range(0, 1023));
          default: addr = 16'($urandom);
        endcase
        send_access(1'($urandom), addr, 8'($urandom));
      end
    end else begin
      depth = $urandom_range(1, 4);
      key   = 8'($urandom);
      bus_write(UnlockPortA, key);
      if (depth >= 2) bus_write(UnlockPortB, 8'hff - key);
      if (depth >= 3) bus_write(UnlockPortB, UnlockMagic);
      if (depth >= 4) bus_write(UnlockPortB, 8'($urandom));
      bus_write(($urandom_range(0, 1) == 0) ? UnlockPortA : UnlockPortB, 8'($urandom));
    end
  endtask

  // With the mode closed nothing decodes: unlock ports are write-only and
  // the reset index and data ports stay silent.
  task automatic test_closed_ports();
    bus_read(UnlockPortA);
    bus_read(UnlockPortB);
    bus_write(16'h0000, 8'h00);
    bus_read(16'h0001);
    bus_read(16'hffff);
  endtask

  // Highest base, index 15 read-back, the read-only index and the top index.
  task automatic test_unlock_readback();
    open_mode(8'hff, 1'b1);
    bus_write(16'h03fc, 8'hff);
    bus_read(16'h03fd);
    bus_write(16'h03fc, 8'h05);
    bus_write(16'h03fd, 8'h00);
    bus_read(16'h03fd);
    bus_write(16'h03fc, 8'hfe);
    bus_write(16'h03fd, 8'hff);
    bus_read(16'h03fd);
  endtask

  // A wrong complement restarts the sequence; an undecoded write and a read
  // in the middle of a good sequence leave it alone. Ends open at base 0.
  task automatic test_broken_unlock();
    logic [7:0] key;
    key = 8'($urandom);
    bus_write(UnlockPortA, key);
    bus_write(UnlockPortB, (8'hff - key) ^ 8'h01);
    key = 8'($urandom);
    bus_write(UnlockPortA, key);
    bus_write(16'h02fb, 8'hff);
    bus_write(UnlockPortB, 8'hff - key);
    bus_read(UnlockPortB);
    bus_write(UnlockPortB, UnlockMagic);
    bus_write(UnlockPortB, 8'h00);
    bus_write(UnlockPortA, 8'hff);
  endtask

  // Step three moves the ports while the mode is open; the bad checksum that
  // follows closes the mode.
  task automatic test_base_move();
    logic [7:0] key;
    key = 8'($urandom);
    bus_write(UnlockPortA, key);
    bus_write(UnlockPortB, 8'hff - key);
    bus_write(UnlockPortB, UnlockMagic);
    bus_write(UnlockPortB, 8'h80);
    bus_read(16'h0200);
    bus_write(UnlockPortA, 8'h00);
    bus_read(16'h0201);
  endtask

  // The receiver holds off while the sender keeps offering beats back to
  // back, so both internal registers fill and the input stalls.
  task automatic test_output_hold();
    wait_idle();
    hold_pending = 1'b1;
    wait (hold_active);
    tx_steady = 1'b1;
    run_session(8'($urandom), 30);
    tx_steady = 1'b0;
  endtask

  // Random sessions and noise under one strap setting.
  task automatic test_strap_phase(input logic xt, input logic disk, input int items);
    int         stop_at;
    logic [7:0] base;
    wait_idle();
    write_cfg(CfgXtAttach, xt);
    write_cfg(CfgDiskPresent, disk);
    stop_at = accesses_sent + items;
    while (accesses_sent < stop_at) begin
      tx_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 6) == 0) begin
        run_noise();
      end else begin
        case ($urandom_range(0, 7))
          0:       base = 8'h00;
          1:       base = 8'hff;
          default: base = 8'($urandom);
        endcase
        run_session(base, $urandom_range(1, 24));
      end
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CfgXtAttach;
    cfg_wdata     = 1'b0;
    errors        = 0;
    accesses_sent = 0;
    burst_left    = 0;
    tx_steady     = 1'b0;
    hold_pending  = 1'b0;
    strap_xt      = 1'b0;
    strap_disk    = 1'b1;
    seq_step      = 3'd0;
    mode_on       = 1'b0;
    want_compl    = 8'h00;
    port_base     = 10'd0;
    sel_index     = 4'd0;
    settings      = '{8'h0c, 8'h00, 8'h00, 8'h00, 8'hfe, 8'h00, 8'h9e, 8'h00,
                      8'h00, 8'hb0, 8'h00, 8'h00, 8'ha0, 8'h00, 8'h00};
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_closed_ports();
    test_unlock_readback();
    test_broken_unlock();
    test_base_move();
    test_output_hold();
    test_strap_phase(1'b1, 1'b1, 200);
    test_strap_phase(1'b1, 1'b0, 200);
    test_strap_phase(1'b0, 1'b0, 200);
    test_strap_phase(1'b0, 1'b1, 200);

    wait_idle();
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // About a thousand accesses, each with random stalls on either side, plus
  // one long hold-off, fit many times over in this window.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
